// File: rtl/app_pkg.sv
package app_pkg;

	// Parse phases; the value of a layout phase is also its field tag
	typedef enum logic [4:0] {
		PH_NODE_ID         = 5'd1,
		PH_DOMAIN          = 5'd2,
		PH_FLAGS           = 5'd3,
		PH_NAME_LEN        = 5'd4,
		PH_NAME_BYTE       = 5'd5,
		PH_HOST_LEN        = 5'd6,
		PH_HOST_BYTE       = 5'd7,
		PH_TOPIC_COUNT     = 5'd8,
		PH_TOPIC_ROLE      = 5'd9,
		PH_TOPIC_LEN       = 5'd10,
		PH_TOPIC_BYTE      = 5'd11,
		PH_EP_COUNT        = 5'd12,
		PH_TYPE_LEN        = 5'd13,
		PH_TYPE_BYTE       = 5'd14,
		PH_ADDR_LEN        = 5'd15,
		PH_ADDR_BYTE       = 5'd16,
		PH_PORT            = 5'd17,
		PH_WILL_QOS        = 5'd18,
		PH_WILL_RETAIN     = 5'd19,
		PH_WILL_TOPIC_LEN  = 5'd20,
		PH_WILL_TOPIC_BYTE = 5'd21,
		PH_WILL_PLEN       = 5'd22,
		PH_WILL_PAYLOAD    = 5'd23,
		PH_DONE            = 5'd24
	} phase_t;

	typedef enum logic [1:0] {
		CAUSE_NONE   = 2'd0,
		CAUSE_DOMAIN = 2'd1,
		CAUSE_TRUNC  = 2'd2
	} cause_t;

	localparam logic [4:0] KIND_IGNORED  = 5'd0;
	localparam logic [7:0] ROLE_SUBSCRIBE = 8'h02;
	localparam int unsigned FLAG_WILL_BIT = 0;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] bytes_left;
		logic [31:0] value_acc;
		logic [1:0]  byte_in_field;
		logic [7:0]  entries_left;
		logic [7:0]  entry_counter;
		logic        will_present;
		logic        role_is_sub;
		cause_t      reject;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase:         PH_NODE_ID,
		bytes_left:    32'd0,
		value_acc:     32'd0,
		byte_in_field: 2'd0,
		entries_left:  8'd0,
		entry_counter: 8'd0,
		will_present:  1'b0,
		role_is_sub:   1'b0,
		reject:        CAUSE_NONE
	};

	typedef struct packed {
		logic [4:0]  field_kind;
		logic [31:0] field_value;
		logic        value_complete;
		logic [7:0]  entry_index;
		logic        topic_subscribed;
		logic        frame_end;
		logic        accepted;
		cause_t      reject_cause;
	} result_t;

	// Bytes per value of a phase; zero for string and payload data bytes
	function automatic logic [2:0] value_width(input phase_t ph);
		logic [2:0] w;
		unique case (ph) inside
			PH_NODE_ID, PH_TOPIC_LEN, PH_PORT, PH_WILL_TOPIC_LEN: w = 3'd2;
			PH_WILL_PLEN: w = 3'd4;
			PH_NAME_BYTE, PH_HOST_BYTE, PH_TOPIC_BYTE, PH_TYPE_BYTE, PH_ADDR_BYTE,
			PH_WILL_TOPIC_BYTE, PH_WILL_PAYLOAD: w = 3'd0;
			default: w = 3'd1;
		endcase
		return w;
	endfunction

endpackage

// File: rtl/app_if.sv
interface app_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;

	modport source (output valid, output payload_byte, output last_byte, input ready);
	modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface app_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  field_kind;
	logic [31:0] field_value;
	logic        value_complete;
	logic [7:0]  entry_index;
	logic        topic_subscribed;
	logic        frame_end;
	logic        accepted;
	logic [1:0]  reject_cause;

	modport source (output valid, output field_kind, output field_value,
		output value_complete, output entry_index, output topic_subscribed,
		output frame_end, output accepted, output reject_cause, input ready);
	modport sink (input valid, input field_kind, input field_value,
		input value_complete, input entry_index, input topic_subscribed,
		input frame_end, input accepted, input reject_cause, output ready);
endinterface

// File: rtl/app_step.sv
module app_step
	import app_pkg::*;
(
	input  parse_state_t st,
	input  logic [7:0]   data_byte,
	input  logic         last,
	input  logic [7:0]   local_domain,
	output parse_state_t nxt,
	output result_t      res
);

	logic [31:0] acc;
	logic [2:0]  k_inc;
	logic [2:0]  wd;
	logic [31:0] bl_dec;
	logic [7:0]  ent_dec;
	logic [7:0]  ent_inc;
	phase_t      after_ep;
	logic        do_after;
	phase_t      ad;
	logic        do_next_ep;

	always_comb begin
		nxt = st;
		res = '0;
		res.field_value = {24'd0, data_byte};
		res.reject_cause = CAUSE_NONE;
		acc = st.value_acc | ({24'd0, data_byte} << {st.byte_in_field, 3'b000});
		k_inc = {1'b0, st.byte_in_field} + 3'd1;
		wd = value_width(st.phase);
		bl_dec = st.bytes_left - 32'd1;
		ent_dec = st.entries_left - 8'd1;
		ent_inc = st.entry_counter + 8'd1;
		after_ep = st.will_present ? PH_WILL_QOS : PH_DONE;
		do_after = 1'b0;
		do_next_ep = 1'b0;
		ad = st.phase;

		if (st.reject != CAUSE_NONE) begin
			res.field_kind = KIND_IGNORED;
		end else if (st.phase == PH_DONE) begin
			res.field_kind = 5'(PH_DONE);
		end else begin
			res.field_kind = 5'(st.phase);
			// tag bytes of a topic or endpoint entry
			case (st.phase) inside
				PH_TOPIC_ROLE: begin
					res.entry_index = st.entry_counter;
					res.topic_subscribed = (data_byte == ROLE_SUBSCRIBE);
				end
				PH_TOPIC_LEN, PH_TOPIC_BYTE: begin
					res.entry_index = st.entry_counter;
					res.topic_subscribed = st.role_is_sub;
				end
				PH_TYPE_LEN, PH_TYPE_BYTE, PH_ADDR_LEN, PH_ADDR_BYTE, PH_PORT: begin
					res.entry_index = st.entry_counter;
				end
				default: ;
			endcase

			if (wd == 3'd0) begin
				// consume one data byte
				nxt.bytes_left = bl_dec;
				if (bl_dec == 32'd0) begin
					do_after = 1'b1;
					ad = st.phase;
				end
			end else if (k_inc >= wd) begin
				// value complete: act on it
				res.field_value = acc;
				res.value_complete = 1'b1;
				nxt.value_acc = 32'd0;
				nxt.byte_in_field = 2'd0;
				unique case (st.phase)
					PH_NODE_ID: nxt.phase = PH_DOMAIN;
					PH_DOMAIN: begin
						if (acc != {24'd0, local_domain}) nxt.reject = CAUSE_DOMAIN;
						else nxt.phase = PH_FLAGS;
					end
					PH_FLAGS: begin
						nxt.will_present = acc[FLAG_WILL_BIT];
						nxt.phase = PH_NAME_LEN;
					end
					PH_TOPIC_COUNT: begin
						nxt.entries_left = acc[7:0];
						nxt.entry_counter = 8'd0;
						nxt.phase = (acc[7:0] != 8'd0) ? PH_TOPIC_ROLE : PH_EP_COUNT;
					end
					PH_TOPIC_ROLE: begin
						nxt.role_is_sub = (acc == {24'd0, ROLE_SUBSCRIBE});
						nxt.phase = PH_TOPIC_LEN;
					end
					PH_EP_COUNT: begin
						nxt.entries_left = acc[7:0];
						nxt.entry_counter = 8'd0;
						nxt.phase = (acc[7:0] != 8'd0) ? PH_TYPE_LEN : after_ep;
					end
					PH_PORT: do_next_ep = 1'b1;
					PH_WILL_QOS: nxt.phase = PH_WILL_RETAIN;
					PH_WILL_RETAIN: nxt.phase = PH_WILL_TOPIC_LEN;
					PH_NAME_LEN, PH_HOST_LEN, PH_TOPIC_LEN, PH_TYPE_LEN, PH_ADDR_LEN,
					PH_WILL_TOPIC_LEN, PH_WILL_PLEN: begin
						// start a string or payload, or skip it when empty
						ad = phase_t'(st.phase + 5'd1);
						if (acc != 32'd0) begin
							nxt.bytes_left = acc;
							nxt.phase = ad;
						end else begin
							do_after = 1'b1;
						end
					end
					default: nxt.phase = PH_DONE;
				endcase
			end else begin
				nxt.value_acc = acc;
				nxt.byte_in_field = k_inc[1:0];
			end

			// advance past a finished string or payload
			if (do_after) begin
				unique case (ad)
					PH_NAME_BYTE:       nxt.phase = PH_HOST_LEN;
					PH_HOST_BYTE:       nxt.phase = PH_TOPIC_COUNT;
					PH_TOPIC_BYTE: begin
						nxt.entries_left = ent_dec;
						nxt.entry_counter = ent_inc;
						nxt.phase = (ent_dec != 8'd0) ? PH_TOPIC_ROLE : PH_EP_COUNT;
					end
					PH_TYPE_BYTE:       nxt.phase = PH_ADDR_LEN;
					PH_ADDR_BYTE:       nxt.phase = PH_PORT;
					PH_WILL_TOPIC_BYTE: nxt.phase = PH_WILL_PLEN;
					default:            nxt.phase = PH_DONE;
				endcase
			end

			// step to the next endpoint
			if (do_next_ep) begin
				nxt.entries_left = ent_dec;
				nxt.entry_counter = ent_inc;
				nxt.phase = (ent_dec != 8'd0) ? PH_TYPE_LEN : after_ep;
			end
		end

		// report the verdict and restart on the final byte
		if (last) begin
			res.frame_end = 1'b1;
			if (nxt.reject != CAUSE_NONE) res.reject_cause = CAUSE_DOMAIN;
			else if (nxt.phase != PH_DONE) res.reject_cause = CAUSE_TRUNC;
			else res.accepted = 1'b1;
			nxt = PARSE_RESET;
		end
	end

endmodule

// File: rtl/announce_payload_parser.sv
// Announce payload parser: takes one payload byte per request on in_ch and returns one tagged
// result per byte on out_ch, one byte per cycle sustained while out_ch is ready. A byte goes into
// an input register, is decoded combinationally against the parse state and lands in the result
// register, which drives out_ch; both stages advance together when the result register is free
// or being drained. The result of the byte marked last carries the verdict (accepted, or the
// reject cause) and the parser then starts fresh for the next payload. Write local_domain
// through cfg_wr_en/cfg_wr_data only while no byte is in flight.
module announce_payload_parser
	import app_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	app_in_if.sink      in_ch,
	app_out_if.source   out_ch
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         out_valid_q;
	result_t      res_q;
	parse_state_t st_q;
	parse_state_t st_nxt;
	result_t      res_nxt;
	logic [7:0]   local_domain_q;
	logic         advance;

	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// hold the domain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) local_domain_q <= 8'd0;
		else if (cfg_wr_en) local_domain_q <= cfg_wr_data;
	end

	// capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_ch.ready) valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.payload_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	app_step u_step (
		.st           (st_q),
		.data_byte    (byte_s1),
		.last         (last_s1),
		.local_domain (local_domain_q),
		.nxt          (st_nxt),
		.res          (res_nxt)
	);

	// advance parse state and result register together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PARSE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) st_q <= st_nxt;
			if (advance) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res_nxt;
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.field_kind       = res_q.field_kind;
	assign out_ch.field_value      = res_q.field_value;
	assign out_ch.value_complete   = res_q.value_complete;
	assign out_ch.entry_index      = res_q.entry_index;
	assign out_ch.topic_subscribed = res_q.topic_subscribed;
	assign out_ch.frame_end        = res_q.frame_end;
	assign out_ch.accepted         = res_q.accepted;
	assign out_ch.reject_cause     = res_q.reject_cause;

`ifndef ASSERT_OFF
	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> st_q.phase == PH_NODE_ID && st_q.reject == CAUSE_NONE)
		else $error("parse state not cleared after final byte");

	a_verdict_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.frame_end |-> !res_q.accepted && res_q.reject_cause == CAUSE_NONE)
		else $error("verdict reported before frame end");

	a_verdict_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_end |->
			(res_q.accepted && res_q.reject_cause == CAUSE_NONE) ||
			(!res_q.accepted && res_q.reject_cause != CAUSE_NONE))
		else $error("frame end without a single verdict");

	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register lost a stalled byte");

	a_ignored_after_reject: assert property (@(posedge clk) disable iff (!arst_n)
		advance && st_q.reject != CAUSE_NONE |=> res_q.field_kind == KIND_IGNORED)
		else $error("byte after reject not ignored");
`endif

endmodule
